/* rtl/assert_macros.svh */
// Assertion helpers shared by the decoder modules.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ps2_dec_pkg.sv */
package ps2_dec_pkg;

    // Special bytes of scan code set 2
    localparam logic [7:0] CODE_EXT     = 8'hE0;
    localparam logic [7:0] CODE_BREAK   = 8'hF0;
    localparam logic [7:0] CODE_PRINT_A = 8'h12;
    localparam logic [7:0] CODE_PRINT_B = 8'h7C;

    localparam int unsigned BYTE_W = 8;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_BREAK     = 3'd1,
        PH_EXT       = 3'd2,
        PH_EXT_BREAK = 3'd3,
        PH_PRINT1    = 3'd4,
        PH_PRINT2    = 3'd5
    } phase_t;

    // One decoded key event
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] key_code;
        logic              released;
    } result_t;

    // True for make codes of used standard set 2 keys (0..131)
    function automatic logic code_is_used(input logic [BYTE_W-1:0] code);
        logic used;
        case (code) inside
            8'h01, [8'h03:8'h07],
            [8'h09:8'h0E],
            8'h11, 8'h12, [8'h14:8'h16],
            [8'h1A:8'h1E],
            [8'h21:8'h26],
            [8'h29:8'h2E],
            [8'h31:8'h36],
            [8'h3A:8'h3E],
            [8'h41:8'h46],
            [8'h49:8'h4E],
            8'h52, 8'h54, 8'h55,
            [8'h58:8'h5B], 8'h5D,
            8'h66,
            8'h69, 8'h6B, 8'h6C,
            [8'h70:8'h7E],
            8'h83: used = 1'b1;
            default: used = 1'b0;
        endcase
        return used;
    endfunction

endpackage

/* rtl/ps2_dec_in.sv */
module ps2_dec_in (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ps2_dec_pkg::BYTE_W-1:0] s_tdata,   // [7:0] scan_byte
    input  logic                         advance,
    output logic                         in_valid,
    output logic [ps2_dec_pkg::BYTE_W-1:0] in_byte
);
    import ps2_dec_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Free slot or slot draining this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture byte on each input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

/* rtl/ps2_dec_fsm.sv */
`include "assert_macros.svh"

module ps2_dec_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [ps2_dec_pkg::BYTE_W-1:0] scan_byte,
    output ps2_dec_pkg::result_t         res
);
    import ps2_dec_pkg::*;

    phase_t phase_reg, phase_next;

    // Next phase
    always_comb begin
        phase_next = PH_IDLE;
        case (phase_reg)
            PH_BREAK:     phase_next = PH_IDLE;
            PH_EXT: begin
                if (scan_byte == CODE_BREAK) begin
                    phase_next = PH_EXT_BREAK;
                end else if (scan_byte == CODE_PRINT_A) begin
                    phase_next = PH_PRINT1;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_EXT_BREAK: phase_next = PH_IDLE;
            PH_PRINT1:    phase_next = (scan_byte == CODE_EXT) ? PH_PRINT2 : PH_IDLE;
            PH_PRINT2: begin
                // completion and abort both end the sequence
                if (scan_byte == CODE_PRINT_B) begin
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (scan_byte == CODE_EXT) begin
                    phase_next = PH_EXT;
                end else if (scan_byte == CODE_BREAK) begin
                    phase_next = PH_BREAK;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // Event output
    always_comb begin
        res.valid    = 1'b0;
        res.key_code = scan_byte;
        res.released = 1'b0;
        case (phase_reg)
            PH_BREAK: begin
                res.valid    = code_is_used(scan_byte);
                res.released = 1'b1;
            end
            PH_EXT, PH_EXT_BREAK, PH_PRINT1, PH_PRINT2: res.valid = 1'b0;
            default: begin
                // prefixes are never in the used set
                res.valid = code_is_used(scan_byte);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    `ASSERT_ALWAYS(a_event_phase,
        !res.valid || phase_reg == PH_IDLE || phase_reg == PH_BREAK
        || phase_reg > PH_PRINT2,
        "key event outside idle or break phase")
    `ASSERT_ALWAYS(a_release_phase, !(res.valid && res.released) || phase_reg == PH_BREAK,
        "release event without preceding break prefix")
    `ASSERT_NEXT(a_break_ends, step && phase_reg == PH_BREAK, phase_reg == PH_IDLE,
        "break phase did not return to idle")

endmodule

/* rtl/ps2_dec_out.sv */
`include "assert_macros.svh"

module ps2_dec_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  ps2_dec_pkg::result_t         res,
    output logic                         out_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ps2_dec_pkg::BYTE_W-1:0] m_tdata,   // [7:0] key_code
    output logic                         m_tuser     // [0] released
);
    import ps2_dec_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] code_reg;
    logic              rel_reg;

    // Slot empty or being taken this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (out_free && advance && res.valid) begin
            code_reg <= res.key_code;
            rel_reg  <= res.released;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = code_reg;
    assign m_tuser  = rel_reg;

    `ASSERT_ALWAYS(a_code_used, !m_tvalid || code_is_used(m_tdata),
        "result carries an unused key code")

endmodule

/* rtl/ps2_set2_scancode_decoder.sv */
// PS/2 scan code set 2 decoder.
//
// Input: one byte from the keyboard link per transfer on s_tdata.
// Output: one key event per transfer, m_tdata = make code of the key,
// m_tuser = 1 for release, 0 for press. Only used standard keys give events;
// extended (E0) and print-screen sequences are consumed silently, and a
// stray byte inside the print-screen sequence drops back to idle.
//
// Path: an event passes through the input register, then the result
// register, before it shows on m_tvalid; a full result register holds it
// back. Throughput: one byte per cycle while m_tready keeps up.
// Bytes that give no event still pass through the input register in order.
//
// Reset (aresetn low, synchronous) empties both registers and puts the
// decoder in idle. When m_tready is held low the result register keeps its
// event, the byte behind it waits in the input register, and s_tready drops
// once both are full; nothing is lost or reordered.
module ps2_set2_scancode_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ps2_dec_pkg::BYTE_W-1:0] s_tdata,   // [7:0] scan_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ps2_dec_pkg::BYTE_W-1:0] m_tdata,   // [7:0] key_code
    output logic                         m_tuser     // [0] released
);
    import ps2_dec_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              advance;
    result_t           res;

    // Byte moves on when the result slot can take its outcome
    assign advance = in_valid && out_free;

    ps2_dec_in u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    ps2_dec_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .scan_byte (in_byte),
        .res       (res)
    );

    ps2_dec_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
